@@ rtl/core/nprq_pkg.sv @@
package nprq_pkg;

  // queue geometry
  localparam int unsigned QueueDepth = 32;
  localparam int unsigned PosBits    = 48;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  typedef logic [PosBits-1:0] pos_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [CntW-1:0]    cnt_t;

  // operation codes
  localparam logic OpAdd      = 1'b0;
  localparam logic OpDispatch = 1'b1;

  // one input item
  typedef struct packed {
    logic operation;
    pos_t request_position;
    pos_t head_position;
  } req_t;

  // one result item
  typedef struct packed {
    logic dispatched;
    pos_t dispatched_position;
    logic add_refused;
    logic queue_empty;
  } rsp_t;

  // position memory access from the scheduler
  typedef struct packed {
    logic we;
    idx_t waddr;
    pos_t wdata;
    logic re;
    idx_t raddr;
  } mem_req_t;

  // absolute distance between two sectors
  function automatic pos_t gap(pos_t a, pos_t b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // circular index increment
  function automatic idx_t idx_next(idx_t a);
    return (a == idx_t'(QueueDepth - 1)) ? '0 : a + 1'b1;
  endfunction

endpackage

@@ rtl/core/nprq_in_if.sv @@
interface nprq_in_if;
  logic                 valid;
  logic                 ready;
  logic                 operation;
  nprq_pkg::pos_t       request_position;
  nprq_pkg::pos_t       head_position;

  modport source (output valid, output operation, output request_position,
                  output head_position, input ready);
  modport sink (input valid, input operation, input request_position,
                input head_position, output ready);
endinterface

@@ rtl/core/nprq_out_if.sv @@
interface nprq_out_if;
  logic                 valid;
  logic                 ready;
  logic                 dispatched;
  nprq_pkg::pos_t       dispatched_position;
  logic                 add_refused;
  logic                 queue_empty;

  modport source (output valid, output dispatched, output dispatched_position,
                  output add_refused, output queue_empty, input ready);
  modport sink (input valid, input dispatched, input dispatched_position,
                input add_refused, input queue_empty, output ready);
endinterface

@@ rtl/core/nprq_ram.sv @@
module nprq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  localparam int unsigned AddrW = $clog2(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[AddrW'(raddr_i)];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/core/nprq_sched.sv @@
module nprq_sched (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  nprq_pkg::req_t     req_i,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output nprq_pkg::rsp_t     rsp_o,
  output nprq_pkg::mem_req_t mem_o,
  input  nprq_pkg::pos_t     mem_rdata_i
);
  import nprq_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StWalk = 3'd1;
  localparam logic [2:0] StTail = 3'd2;
  localparam logic [2:0] StPop  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0] st_q, st_d;
  idx_t       head_q, head_d;
  cnt_t       count_q, count_d;
  idx_t       addr_q, addr_d;
  idx_t       step_q, step_d;
  logic       found_q, found_d;
  pos_t       newp_q, newp_d;
  pos_t       ref_q, ref_d;
  pos_t       carry_q, carry_d;
  rsp_t       rsp_q, rsp_d;

  logic       accept;
  logic       hit;
  logic       last_step;
  idx_t       addr_nxt;

  assign accept    = req_valid_i && (st_q == StIdle);
  assign addr_nxt  = idx_next(addr_q);
  assign last_step = (step_q == idx_t'(count_q - 1'b1));
  // new request goes in front when not farther than the entry
  assign hit       = !found_q && (gap(newp_q, ref_q) <= gap(mem_rdata_i, ref_q));

  assign req_ready_o = (st_q == StIdle);
  assign rsp_valid_o = (st_q == StDone);
  assign rsp_o       = rsp_q;

  // walk, shift and pop sequencing
  always_comb begin
    st_d        = st_q;
    head_d      = head_q;
    count_d     = count_q;
    addr_d      = addr_q;
    step_d      = step_q;
    found_d     = found_q;
    newp_d      = newp_q;
    ref_d       = ref_q;
    carry_d     = carry_q;
    rsp_d       = rsp_q;
    mem_o.we    = 1'b0;
    mem_o.waddr = addr_q;
    mem_o.wdata = newp_q;
    mem_o.re    = 1'b0;
    mem_o.raddr = addr_nxt;

    unique case (st_q)
      StIdle: begin
        mem_o.re    = 1'b1;
        mem_o.raddr = head_q;
        if (accept) begin
          newp_d  = req_i.request_position;
          ref_d   = req_i.head_position;
          addr_d  = head_q;
          step_d  = '0;
          found_d = 1'b0;
          rsp_d   = '0;
          if (req_i.operation == OpDispatch) begin
            if (count_q == '0) begin
              rsp_d.queue_empty = 1'b1;
              st_d              = StDone;
            end else begin
              st_d = StPop;
            end
          end else if (count_q == cnt_t'(QueueDepth)) begin
            rsp_d.add_refused = 1'b1;
            st_d              = StDone;
          end else if (count_q == '0) begin
            st_d = StTail;
          end else begin
            st_d = StWalk;
          end
        end
      end
      StWalk: begin
        // entry data comes from the registered read issued in the cycle before; write back shifted value
        mem_o.re    = !last_step;
        mem_o.we    = hit || found_q;
        mem_o.wdata = hit ? newp_q : carry_q;
        if (hit || found_q) begin
          carry_d = mem_rdata_i;
        end else begin
          ref_d = mem_rdata_i;
        end
        found_d = found_q || hit;
        addr_d  = addr_nxt;
        step_d  = step_q + 1'b1;
        if (last_step) begin
          st_d = StTail;
        end
      end
      StTail: begin
        mem_o.we    = 1'b1;
        mem_o.wdata = found_q ? carry_q : newp_q;
        count_d     = count_q + 1'b1;
        st_d        = StDone;
      end
      StPop: begin
        rsp_d.dispatched          = 1'b1;
        rsp_d.dispatched_position = mem_rdata_i;
        rsp_d.queue_empty         = (count_q == cnt_t'(1));
        head_d                    = idx_next(head_q);
        count_d                   = count_q - 1'b1;
        st_d                      = StDone;
      end
      StDone: begin
        if (rsp_ready_i) begin
          st_d = StIdle;
        end
      end
      default: begin
        st_d = StIdle;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIdle;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      st_q    <= st_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // walk payload
  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    step_q  <= step_d;
    found_q <= found_d;
    newp_q  <= newp_d;
    ref_q   <= ref_d;
    carry_q <= carry_d;
    rsp_q   <= rsp_d;
  end
endmodule

@@ rtl/core/nearest_position_request_queue.sv @@
// channel | dir | fields                                                  | transfer
// req_i   | in  | operation, request_position, head_position              | valid & ready
// rsp_o   | out | dispatched, dispatched_position, add_refused, queue_empty | valid & ready
//
// an add walks the queued entries, reading one stored position per cycle from
// the single read port, and then writes the tail
// a dispatch or a refused add needs no walk
// one item is worked at a time; the result register lets the next item in while a
// result waits, and a stalled result stops the scheduler only once a second is ready
// reset empties the queue at once; stored positions need no clearing
module nearest_position_request_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  nprq_in_if.sink    req_i,
  nprq_out_if.source rsp_o
);
  import nprq_pkg::*;

  req_t     req;
  rsp_t     sched_rsp;
  logic     sched_rsp_valid;
  logic     sched_rsp_ready;
  mem_req_t mem_req;
  pos_t     mem_rdata;

  logic     out_valid_q, out_valid_d;
  rsp_t     out_q;

  assign req.operation        = req_i.operation;
  assign req.request_position = req_i.request_position;
  assign req.head_position    = req_i.head_position;

  // scheduler
  nprq_sched u_sched (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req),
    .rsp_valid_o (sched_rsp_valid),
    .rsp_ready_i (sched_rsp_ready),
    .rsp_o       (sched_rsp),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // position store, circular
  nprq_ram #(
    .Width (PosBits),
    .Depth (QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // result register
  assign sched_rsp_ready = !out_valid_q || rsp_o.ready;
  always_comb begin
    out_valid_d = out_valid_q;
    if (sched_rsp_valid && sched_rsp_ready) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sched_rsp_valid && sched_rsp_ready) begin
      out_q <= sched_rsp;
    end
  end

  assign rsp_o.valid               = out_valid_q;
  assign rsp_o.dispatched          = out_q.dispatched;
  assign rsp_o.dispatched_position = out_q.dispatched_position;
  assign rsp_o.add_refused         = out_q.add_refused;
  assign rsp_o.queue_empty         = out_q.queue_empty;
endmodule

@@ rtl/core/nprq_check.sv @@
module nprq_check (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           req_valid_i,
  input logic           req_ready_i,
  input logic           rsp_valid_i,
  input logic           rsp_ready_i,
  input logic           dispatched_i,
  input nprq_pkg::pos_t dispatched_position_i,
  input logic           add_refused_i,
  input logic           queue_empty_i
);
  import nprq_pkg::*;

  logic       req_xfer;
  logic       rsp_xfer;
  cnt_t       cnt_q;
  logic [1:0] outst_q;

  assign req_xfer = req_valid_i && req_ready_i;
  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  // queue fill as seen from delivered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (rsp_xfer) begin
      if (dispatched_i) begin
        cnt_q <= cnt_q - 1'b1;
      end else if (!add_refused_i && !queue_empty_i) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // items taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else if (req_xfer && !rsp_xfer) begin
      outst_q <= outst_q + 1'b1;
    end else if (rsp_xfer && !req_xfer) begin
      outst_q <= outst_q - 1'b1;
    end
  end

  // refusal only when full
  a_refused_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_xfer && add_refused_i |-> cnt_q == cnt_t'(QueueDepth))
    else $error("add refused while queue not full");

  // dispatch only from a nonempty queue, empty flag follows the fill
  a_dispatch_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_xfer && dispatched_i |-> cnt_q != '0 && queue_empty_i == (cnt_q == cnt_t'(1)))
    else $error("dispatch result disagrees with queue fill");

  // no dispatch position without a dispatch
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !dispatched_i |-> dispatched_position_i == '0)
    else $error("position reported without dispatch");

  // at most one item in work and one result waiting
  a_outstanding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q != 2'd3)
    else $error("too many items in flight");

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(dispatched_position_i))
    else $error("result changed while stalled");
endmodule

bind nearest_position_request_queue nprq_check u_check (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .req_valid_i           (req_i.valid),
  .req_ready_i           (req_i.ready),
  .rsp_valid_i           (rsp_o.valid),
  .rsp_ready_i           (rsp_o.ready),
  .dispatched_i          (rsp_o.dispatched),
  .dispatched_position_i (rsp_o.dispatched_position),
  .add_refused_i         (rsp_o.add_refused),
  .queue_empty_i         (rsp_o.queue_empty)
);
